@@ rtl/core/gbp_pkg.sv @@
package gbp_pkg;

	localparam int ACC_W = 34;
	localparam int SCALE_W = 10;
	localparam int MAG_W = ACC_W + SCALE_W;

	localparam longint unsigned ACC_CAP_L = 64'h3_FFFF_FFFF;
	localparam logic [ACC_W-1:0] ACC_CAP = ACC_W'(ACC_CAP_L);
	// Largest accumulator value that still takes one more digit without clipping.
	localparam logic [ACC_W-1:0] ACC_ADD_MAX = ACC_W'((ACC_CAP_L - 64'd9) / 64'd10);

	localparam logic [13:0] INT_FIELD_MAX = 14'd16383;
	localparam logic [MAG_W-1:0] AXIS_POS_MAX = MAG_W'(64'h7FFF_FFFF);
	localparam logic [MAG_W-1:0] AXIS_NEG_LIM = MAG_W'(64'h8000_0000);
	localparam logic [31:0] AXIS_POS_SAT = 32'h7FFF_FFFF;
	localparam logic [31:0] AXIS_NEG_SAT = 32'h8000_0000;

	localparam logic [7:0] TERM_RESET = 8'd13;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_F = 8'h46;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_L = 8'h4C;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_U = 8'h55;
	localparam logic [7:0] CH_V = 8'h56;
	localparam logic [7:0] CH_W = 8'h57;

	localparam logic [1:0] CL_NONE = 2'd0;
	localparam logic [1:0] CL_G = 2'd1;
	localparam logic [1:0] CL_M = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		K_NONE = 4'd0,
		K_N    = 4'd1,
		K_G    = 4'd2,
		K_M    = 4'd3,
		K_F    = 4'd4,
		K_L    = 4'd5,
		K_W    = 4'd6,
		K_U    = 4'd7,
		K_V    = 4'd8,
		K_A    = 4'd9
	} kind_t;

	// One finished word and/or end of line, passed from front to back.
	typedef struct packed {
		kind_t            kind;
		logic [ACC_W-1:0] acc;
		logic             neg;
		logic [1:0]       fd;
		logic             emit;
	} word_ev_t;

	typedef struct packed {
		logic [13:0]        block_number;
		logic [1:0]         code_letter;
		logic [6:0]         code_number;
		logic [13:0]        feed_value;
		logic [13:0]        repeat_count;
		logic signed [31:0] x_milli;
		logic signed [31:0] y_milli;
		logic signed [31:0] z_milli;
		logic signed [31:0] a_milli;
	} block_t;

	localparam block_t BLOCK_CLEAR = '{
		block_number: 14'd0,
		code_letter:  CL_NONE,
		code_number:  7'd0,
		feed_value:   14'd0,
		repeat_count: 14'd1,
		x_milli:      32'sd0,
		y_milli:      32'sd0,
		z_milli:      32'sd0,
		a_milli:      32'sd0
	};

	function automatic kind_t kind_of(input logic [7:0] c);
		kind_t k;
		unique case (c)
			CH_N: k = K_N;
			CH_G: k = K_G;
			CH_M: k = K_M;
			CH_F: k = K_F;
			CH_L: k = K_L;
			CH_W: k = K_W;
			CH_U: k = K_U;
			CH_V: k = K_V;
			CH_A: k = K_A;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic is_axis(input kind_t k);
		return (k == K_W) || (k == K_U) || (k == K_V) || (k == K_A);
	endfunction

	// Scale that brings an axis value with fd fraction digits to thousandths.
	function automatic logic [SCALE_W-1:0] pow10_of(input logic [1:0] fd);
		logic [SCALE_W-1:0] s;
		case (fd)
			2'd0: s = SCALE_W'(1000);
			2'd1: s = SCALE_W'(100);
			2'd2: s = SCALE_W'(10);
			default: s = SCALE_W'(1);
		endcase
		return s;
	endfunction

endpackage

@@ rtl/core/gbp_if.sv @@
interface gbp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

interface gbp_block_if;
	logic            valid;
	logic            ready;
	gbp_pkg::block_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/gbp_front.sv @@
module gbp_front #(
	parameter int AXIS_WORD_CHARS = 15,
	parameter int INT_WORD_DIGITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	gbp_char_if.sink          char_ch,
	output logic              push,
	output gbp_pkg::word_ev_t push_ev,
	input  logic              full
);
	import gbp_pkg::*;

	localparam int MAX_LIM = (AXIS_WORD_CHARS > INT_WORD_DIGITS) ? AXIS_WORD_CHARS
		: INT_WORD_DIGITS;
	localparam int CNT_W = $clog2(MAX_LIM + 1);
	localparam logic [CNT_W-1:0] LIM_AXIS = CNT_W'(AXIS_WORD_CHARS);
	localparam logic [CNT_W-1:0] LIM_INT = CNT_W'(INT_WORD_DIGITS);
	localparam logic [CNT_W-1:0] LIM_CODE = CNT_W'(2);

	logic [7:0]       term_q;
	kind_t            kind_q, kind_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic             neg_q, neg_d;
	logic             point_q, point_d;
	logic [1:0]       fd_q, fd_d;
	logic             started_q, started_d;
	logic             ended_q, ended_d;

	logic [7:0]       c;
	logic             take;
	logic             is_term;
	logic             digit;
	logic [ACC_W-1:0] acc_add;
	logic             early;
	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] count_inc;

	logic [ACC_W-1:0] f_acc;
	logic             f_neg, f_point, f_started, f_ended;
	logic [1:0]       f_fd;

	assign c = char_ch.char_in;
	assign char_ch.ready = !full;
	assign take = char_ch.valid && char_ch.ready;
	assign is_term = (c == term_q);
	assign digit = (c >= CH_0) && (c <= CH_9);
	assign count_inc = count_q + CNT_W'(1);

	// Multiply by ten and add, clipping at the accumulator cap.
	assign acc_add = (acc_q > ACC_ADD_MAX) ? ACC_CAP
		: (acc_q << 3) + (acc_q << 1) + ACC_W'(c[3:0]);

	always_comb begin
		case (kind_q) inside
			K_F: early = (c == CH_SPACE) || (c == CH_N) || (c == CH_L);
			K_L: early = (c == CH_SPACE) || (c == CH_N) || (c == CH_F);
			K_W, K_U, K_V, K_A: early = (c == CH_SPACE) || (c == CH_N);
			default: early = 1'b0;
		endcase
	end

	always_comb begin
		case (kind_q) inside
			K_G, K_M: limit = LIM_CODE;
			K_W, K_U, K_V, K_A: limit = LIM_AXIS;
			default: limit = LIM_INT;
		endcase
	end

	// Effect of one character on the open word.
	always_comb begin
		f_acc = acc_q;
		f_neg = neg_q;
		f_point = point_q;
		f_fd = fd_q;
		f_started = started_q;
		f_ended = ended_q;
		unique case (kind_q) inside
			K_N, K_G, K_M: begin
				if (!ended_q && !((c == CH_SPACE) && !started_q)) begin
					if (digit) begin
						f_started = 1'b1;
						f_acc = acc_add;
					end else begin
						f_ended = 1'b1;
					end
				end
			end
			K_F, K_L: begin
				if (digit) f_acc = acc_add;
			end
			K_W, K_U, K_V, K_A: begin
				if (!ended_q) begin
					if (c == CH_MINUS) begin
						if (started_q) begin
							f_ended = 1'b1;
						end else begin
							f_started = 1'b1;
							f_neg = 1'b1;
						end
					end else if (c == CH_POINT) begin
						if (point_q) begin
							f_ended = 1'b1;
						end else begin
							f_point = 1'b1;
							f_started = 1'b1;
						end
					end else if (digit) begin
						f_started = 1'b1;
						if (!point_q) begin
							f_acc = acc_add;
						end else if (fd_q != 2'd3) begin
							f_acc = acc_add;
							f_fd = fd_q + 2'd1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		logic clr;
		clr = 1'b0;
		kind_d = kind_q;
		count_d = count_q;
		acc_d = acc_q;
		neg_d = neg_q;
		point_d = point_q;
		fd_d = fd_q;
		started_d = started_q;
		ended_d = ended_q;
		push = 1'b0;
		push_ev = '{kind: kind_q, acc: acc_q, neg: neg_q, fd: fd_q, emit: 1'b0};
		if (take) begin
			if (is_term) begin
				push = 1'b1;
				push_ev.emit = 1'b1;
				clr = 1'b1;
			end else if ((kind_q != K_NONE) && !early) begin
				if (count_inc >= limit) begin
					push = 1'b1;
					push_ev.acc = f_acc;
					push_ev.neg = f_neg;
					push_ev.fd = f_fd;
					clr = 1'b1;
				end else begin
					count_d = count_inc;
					acc_d = f_acc;
					neg_d = f_neg;
					point_d = f_point;
					fd_d = f_fd;
					started_d = f_started;
					ended_d = f_ended;
				end
			end else begin
				push = (kind_q != K_NONE);
				clr = 1'b1;
			end
		end
		if (clr) begin
			kind_d = K_NONE;
			count_d = '0;
			acc_d = '0;
			neg_d = 1'b0;
			point_d = 1'b0;
			fd_d = 2'd0;
			started_d = 1'b0;
			ended_d = 1'b0;
		end
		// A character that neither ends the line nor feeds a word may open one.
		if (take && !is_term && !((kind_q != K_NONE) && !early)) begin
			kind_d = kind_of(c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= TERM_RESET;
			kind_q <= K_NONE;
			count_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			point_q <= 1'b0;
			fd_q <= 2'd0;
			started_q <= 1'b0;
			ended_q <= 1'b0;
		end else begin
			if (cfg_we) term_q <= cfg_wdata;
			kind_q <= kind_d;
			count_q <= count_d;
			acc_q <= acc_d;
			neg_q <= neg_d;
			point_q <= point_d;
			fd_q <= fd_d;
			started_q <= started_d;
			ended_q <= ended_d;
		end
	end

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == K_NONE) |-> (count_q == '0 && acc_q == '0))
		else $error("front: idle word holds stale count or value");

endmodule

@@ rtl/core/gbp_fifo.sv @@
module gbp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gbp_pkg::word_ev_t push_ev,
	output logic              full,
	input  logic              pop,
	output logic              rd_valid,
	output gbp_pkg::word_ev_t rd_ev
);
	import gbp_pkg::*;

	word_ev_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_ev = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= QPTR_W'((32'(wr_ptr_q) + 1) % QUEUE_DEPTH);
			if (pop) rd_ptr_q <= QPTR_W'((32'(rd_ptr_q) + 1) % QUEUE_DEPTH);
			case ({push, pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("fifo: push into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd_valid)
		else $error("fifo: pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("fifo: occupancy out of range");

endmodule

@@ rtl/core/gbp_back.sv @@
module gbp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  gbp_pkg::word_ev_t q_ev,
	output logic              q_pop,
	gbp_block_if.source       block_ch
);
	import gbp_pkg::*;

	logic               valid_s1;
	kind_t              kind_s1;
	logic               neg_s1;
	logic               emit_s1;
	logic [MAG_W-1:0]   mag_s1;

	block_t             fields_q;
	block_t             out_q;
	logic               out_valid_q;

	logic [SCALE_W-1:0] scale;
	logic [MAG_W-1:0]   prod;
	logic               apply;
	logic [13:0]        int_sat;
	logic [31:0]        axis_val;
	block_t             merged;

	assign scale = is_axis(q_ev.kind) ? pow10_of(q_ev.fd) : SCALE_W'(1);
	assign prod = MAG_W'(q_ev.acc) * MAG_W'(scale);

	// Retire the word in stage 1 unless it closes a line and the output is still held.
	assign apply = valid_s1 && (!emit_s1 || !out_valid_q || block_ch.ready);
	assign q_pop = q_valid && (!valid_s1 || apply);

	assign int_sat = (mag_s1 > MAG_W'(INT_FIELD_MAX)) ? INT_FIELD_MAX : mag_s1[13:0];

	always_comb begin
		if (neg_s1) begin
			axis_val = (mag_s1 >= AXIS_NEG_LIM) ? AXIS_NEG_SAT : (32'd0 - mag_s1[31:0]);
		end else begin
			axis_val = (mag_s1 > AXIS_POS_MAX) ? AXIS_POS_SAT : mag_s1[31:0];
		end
	end

	always_comb begin
		merged = fields_q;
		unique case (kind_s1)
			K_N: merged.block_number = int_sat;
			K_G: begin
				merged.code_letter = CL_G;
				merged.code_number = int_sat[6:0];
			end
			K_M: begin
				merged.code_letter = CL_M;
				merged.code_number = int_sat[6:0];
			end
			K_F: merged.feed_value = int_sat;
			K_L: merged.repeat_count = int_sat;
			K_W: merged.x_milli = axis_val;
			K_U: merged.y_milli = axis_val;
			K_V: merged.z_milli = axis_val;
			K_A: merged.a_milli = axis_val;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_s1 <= q_ev.kind;
			neg_s1 <= q_ev.neg;
			emit_s1 <= q_ev.emit;
			mag_s1 <= prod;
		end
		if (apply && emit_s1) out_q <= merged;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			fields_q <= BLOCK_CLEAR;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (apply) begin
				valid_s1 <= 1'b0;
			end
			if (apply && emit_s1) begin
				out_valid_q <= 1'b1;
			end else if (block_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (apply) fields_q <= emit_s1 ? BLOCK_CLEAR : merged;
		end
	end

	assign block_ch.valid = out_valid_q;
	assign block_ch.data = out_q;

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(apply && emit_s1) |=> out_valid_q)
		else $error("back: finished block not presented");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !block_ch.ready) |-> !(apply && emit_s1))
		else $error("back: pending block overwritten");

endmodule

@@ rtl/core/gcode_block_parser_top.sv @@
// A block is offered on block_ch once the transaction that carries its line terminator has
// passed the queue write, the scale multiply into stage 1 and the merge into the output reg.
// Throughput: one character per cycle while the four-entry word queue has room; the back
// retires one queue entry per cycle unless a finished block waits on a held block_ch.
// Reset (arst_n low): terminator returns to 13, no word open, queue empty, block fields
// cleared to zero with repeat count one, no block offered.
module gcode_block_parser_top #(
	parameter int AXIS_WORD_CHARS = 15,
	parameter int INT_WORD_DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	gbp_char_if.sink    char_ch,
	gbp_block_if.source block_ch
);
	import gbp_pkg::*;

	// Front to queue: one entry per finished word or line end.
	logic     push;
	word_ev_t push_ev;
	logic     full;

	// Queue to back.
	logic     rd_valid;
	word_ev_t rd_ev;
	logic     pop;

	// Front: hold the terminator register, classify each character, accumulate the open
	// word's digits and push it on completion. A terminator pushes an entry that both
	// closes the open word (if any) and marks end of line.
	gbp_front #(
		.AXIS_WORD_CHARS (AXIS_WORD_CHARS),
		.INT_WORD_DIGITS (INT_WORD_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.char_ch   (char_ch),
		.push      (push),
		.push_ev   (push_ev),
		.full      (full)
	);

	// Queue: decouple character intake from block output stalls.
	gbp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ev  (push_ev),
		.full     (full),
		.pop      (pop),
		.rd_valid (rd_valid),
		.rd_ev    (rd_ev)
	);

	// Back: scale axis values to thousandths, saturate, merge into the block, and on line
	// end load the output register and clear the block.
	gbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (rd_valid),
		.q_ev     (rd_ev),
		.q_pop    (pop),
		.block_ch (block_ch)
	);

endmodule

@@ dv/gcode_block_parser_top_tb.sv @@
`timescale 1ns / 100ps

module gcode_block_parser_top_tb;
	import gbp_pkg::*;

	localparam int AXIS_CHARS = 15;
	localparam int INT_DIGITS = 4;

	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 180;
	localparam int HOLD_CYCLES = 400;
	// Front queue of four words plus the back end's stage 1 and output register, with margin.
	localparam int SETTLE_CYCLES = 12;
	localparam longint TIMEOUT_NS = 64'd5_000_000;

	localparam longint unsigned ACC_TOP = 64'h3_FFFF_FFFF;
	localparam logic [7:0] TERM_LF = 8'd10;
	localparam logic [7:0] TERM_LOW = 8'd0;
	localparam logic [7:0] TERM_HIGH = 8'd255;

	// Per-phase idle enables, bit n for phase n. Phase 0 runs the sender flat out
	// so that the long receiver hold backs the parser up; phase 6 idles neither side.
	localparam logic [NUM_PHASES-1:0] TX_IDLE_MASK = 8'b1011_0110;
	localparam logic [NUM_PHASES-1:0] RX_IDLE_MASK = 8'b1010_1101;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	gbp_char_if char_ch ();
	gbp_block_if block_ch ();

	gcode_block_parser_top #(
		.AXIS_WORD_CHARS(AXIS_CHARS),
		.INT_WORD_DIGITS(INT_DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.char_ch(char_ch),
		.block_ch(block_ch)
	);

	always #5 clk = ~clk;

	// Characters waiting to be offered, and parsed blocks waiting to come out.
	logic [7:0] pending[$];
	block_t blocks_due[$];
	int queued;
	int fail_cnt;

	// Idle controls, set per phase by the sequencer.
	bit tx_idle;
	bit rx_idle;
	bit hold_req;
	bit hold_begun;
	int tx_gap;
	int rx_stall;
	int hold_left;

	// Parser state mirrored by the predictor.
	logic [7:0] term_chr;
	kind_t wk;
	int unsigned wcount;
	longint unsigned acc;
	bit neg;
	bit pt;
	bit started;
	bit ended;
	logic [1:0] fd;
	block_t line_fields;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void add_digit(input logic [7:0] d);
		// Clip the accumulator at its 34-bit ceiling instead of wrapping.
		if (acc > (ACC_TOP - 64'd9) / 64'd10)
			acc = ACC_TOP;
		else
			acc = acc * 64'd10 + longint'(d);
	endfunction

	function automatic logic [13:0] sat14();
		return (acc > 64'd16383) ? 14'd16383 : acc[13:0];
	endfunction

	// Commit the open word into the line fields and clear the word state.
	function automatic void close_word();
		longint unsigned mag;
		longint unsigned scale;
		logic [31:0] v;
		case (fd)
			2'd0: scale = 64'd1000;
			2'd1: scale = 64'd100;
			2'd2: scale = 64'd10;
			default: scale = 64'd1;
		endcase
		mag = acc * scale;
		if (neg)
			v = (mag >= 64'h8000_0000) ? AXIS_NEG_SAT : 32'd0 - mag[31:0];
		else
			v = (mag > 64'h7FFF_FFFF) ? AXIS_POS_SAT : mag[31:0];
		case (wk)
			K_N: line_fields.block_number = sat14();
			K_G: begin
				line_fields.code_letter = CL_G;
				line_fields.code_number = 7'(sat14());
			end
			K_M: begin
				line_fields.code_letter = CL_M;
				line_fields.code_number = 7'(sat14());
			end
			K_F: line_fields.feed_value = sat14();
			K_L: line_fields.repeat_count = sat14();
			K_W: line_fields.x_milli = v;
			K_U: line_fields.y_milli = v;
			K_V: line_fields.z_milli = v;
			K_A: line_fields.a_milli = v;
			default: ;
		endcase
		wk = K_NONE;
		wcount = 0;
		acc = 0;
		neg = 1'b0;
		pt = 1'b0;
		fd = 2'd0;
		started = 1'b0;
		ended = 1'b0;
	endfunction

	function automatic int unsigned word_cap();
		if (wk == K_G || wk == K_M)
			return 2;
		if (wk == K_W || wk == K_U || wk == K_V || wk == K_A)
			return AXIS_CHARS;
		return INT_DIGITS;
	endfunction

	function automatic bit ends_word_early(input logic [7:0] c);
		case (wk)
			K_F: return c == CH_SPACE || c == CH_N || c == CH_L;
			K_L: return c == CH_SPACE || c == CH_N || c == CH_F;
			K_W, K_U, K_V, K_A: return c == CH_SPACE || c == CH_N;
			default: return 1'b0;
		endcase
	endfunction

	function automatic kind_t start_kind(input logic [7:0] c);
		case (c)
			CH_N: return K_N;
			CH_G: return K_G;
			CH_M: return K_M;
			CH_F: return K_F;
			CH_L: return K_L;
			CH_W: return K_W;
			CH_U: return K_U;
			CH_V: return K_V;
			CH_A: return K_A;
			default: return K_NONE;
		endcase
	endfunction

	// Feed one character into the open word.
	function automatic void absorb_char(input logic [7:0] c);
		bit dig;
		dig = (c >= CH_0) && (c <= CH_9);
		if (wk == K_N || wk == K_G || wk == K_M) begin
			// Leading spaces are skipped; the first non-digit closes the digit run.
			if (ended)
				return;
			if (c == CH_SPACE && !started)
				return;
			if (dig) begin
				started = 1'b1;
				add_digit(c - CH_0);
			end else begin
				ended = 1'b1;
			end
		end else if (wk == K_F || wk == K_L) begin
			if (dig)
				add_digit(c - CH_0);
		end else begin
			// Axis text: optional leading minus, integer digits, one point,
			// at most three fraction digits kept.
			if (ended)
				return;
			if (c == CH_MINUS) begin
				if (started) begin
					ended = 1'b1;
				end else begin
					started = 1'b1;
					neg = 1'b1;
				end
			end else if (c == CH_POINT) begin
				if (pt) begin
					ended = 1'b1;
				end else begin
					pt = 1'b1;
					started = 1'b1;
				end
			end else if (dig) begin
				started = 1'b1;
				if (!pt) begin
					add_digit(c - CH_0);
				end else if (fd < 2'd3) begin
					add_digit(c - CH_0);
					fd++;
				end
			end
		end
	endfunction

	// Advance the predictor by one accepted character; queue a block on a terminator.
	function automatic void parse_char(input logic [7:0] c);
		if (c == term_chr) begin
			close_word();
			blocks_due.push_back(line_fields);
			line_fields = BLOCK_CLEAR;
			return;
		end
		if (wk != K_NONE) begin
			if (ends_word_early(c)) begin
				close_word();
			end else begin
				absorb_char(c);
				wcount++;
				if (wcount >= word_cap())
					close_word();
				return;
			end
		end
		wk = start_kind(c);
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	function automatic void cmp_field(input string name, input longint want, input longint got);
		if (want != got) begin
			fail_cnt++;
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endfunction

	function automatic void check_block(input block_t got);
		block_t want;
		if (blocks_due.size() == 0) begin
			fail_cnt++;
			$error("block received with no block expected");
			return;
		end
		want = blocks_due.pop_front();
		cmp_field("block_number", longint'(want.block_number), longint'(got.block_number));
		cmp_field("code_letter", longint'(want.code_letter), longint'(got.code_letter));
		cmp_field("code_number", longint'(want.code_number), longint'(got.code_number));
		cmp_field("feed_value", longint'(want.feed_value), longint'(got.feed_value));
		cmp_field("repeat_count", longint'(want.repeat_count), longint'(got.repeat_count));
		cmp_field("x_milli", longint'(want.x_milli), longint'(got.x_milli));
		cmp_field("y_milli", longint'(want.y_milli), longint'(got.y_milli));
		cmp_field("z_milli", longint'(want.z_milli), longint'(got.z_milli));
		cmp_field("a_milli", longint'(want.a_milli), longint'(got.a_milli));
	endfunction

	// Most gaps are short; about one in ten is long.
	function automatic int pick_gap(input bit en);
		int r;
		if (!en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Driver: offer pending characters, hold each until its transaction
	// completes, predict at acceptance.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_ch.valid <= 1'b0;
			char_ch.char_in <= 8'd0;
			tx_gap = 0;
		end else begin
			if (char_ch.valid && char_ch.ready)
				parse_char(char_ch.char_in);
			// Only move on once the current character has been taken.
			if (!char_ch.valid || char_ch.ready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					char_ch.valid <= 1'b0;
				end else if (pending.size() != 0) begin
					char_ch.char_in <= pending.pop_front();
					char_ch.valid <= 1'b1;
					tx_gap = pick_gap(tx_idle);
				end else begin
					char_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each block transaction, stall ready at random, and
	// once hold ready low long enough for the parser to stall its input.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_ch.ready <= 1'b0;
			rx_stall = 0;
			hold_left = 0;
		end else begin
			if (block_ch.valid && block_ch.ready)
				check_block(block_ch.data);
			if (hold_req && !hold_begun) begin
				hold_begun = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				block_ch.ready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall--;
				block_ch.ready <= 1'b0;
			end else begin
				block_ch.ready <= 1'b1;
				rx_stall = pick_gap(rx_idle);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------

	task automatic queue_char(input logic [7:0] c);
		pending.push_back(c);
		queued++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_char(s[i]);
	endtask

	// Queue n digits; now and then all nines to reach the field maxima
	// and the axis saturation limits.
	task automatic queue_digits(input int n);
		bit nines;
		nines = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < n; i++)
			queue_char(nines ? CH_9 : CH_0 + 8'($urandom_range(0, 9)));
	endtask

	task automatic queue_word();
		int sel;
		int n;
		sel = $urandom_range(0, 8);
		case (sel)
			0, 1, 2: begin
				// Fixed-length words: exact fill, leading space, early stop, overrun.
				queue_char(sel == 0 ? CH_N : (sel == 1 ? CH_G : CH_M));
				n = (sel == 0) ? INT_DIGITS : 2;
				case ($urandom_range(0, 3))
					0: queue_digits(n);
					1: begin
						queue_char(CH_SPACE);
						queue_digits(n - 1);
					end
					2: begin
						queue_digits($urandom_range(1, n));
						queue_char(8'($urandom_range(0, 255)));
					end
					default: queue_digits(n + $urandom_range(1, 2));
				endcase
			end
			3, 4: begin
				queue_char(sel == 3 ? CH_F : CH_L);
				queue_digits($urandom_range(0, INT_DIGITS));
			end
			default: begin
				case (sel)
					5: queue_char(CH_W);
					6: queue_char(CH_U);
					7: queue_char(CH_V);
					default: queue_char(CH_A);
				endcase
				if ($urandom_range(0, 2) == 0)
					queue_char(CH_MINUS);
				queue_digits($urandom_range(0, 10));
				if ($urandom_range(0, 3) != 0) begin
					queue_char(CH_POINT);
					queue_digits($urandom_range(0, 6));
				end
				// Occasionally break the number with a stray sign or point.
				if ($urandom_range(0, 7) == 0) begin
					queue_char($urandom_range(0, 1) ? CH_MINUS : CH_POINT);
					queue_digits($urandom_range(1, 2));
				end
			end
		endcase
		if ($urandom_range(0, 1))
			queue_char(CH_SPACE);
	endtask

	// One program line: mostly well-formed words, sometimes raw noise;
	// leave the terminator off now and then so that lines run together.
	task automatic queue_line();
		int n;
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++)
				queue_char(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++)
				queue_word();
		end
		if ($urandom_range(0, 9) != 0)
			queue_char(term_chr);
	endtask

	// Wait until every character is taken and every block has come out,
	// then let the parser settle before touching the terminator register.
	task automatic drain();
		while (pending.size() != 0 || char_ch.valid || blocks_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_term(input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		term_chr = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] phase_term(input int ph);
		case (ph)
			1: return TERM_LOW;
			2: return TERM_HIGH;
			3: return CH_N;
			4: return CH_SPACE;
			5: return TERM_LF;
			6: return 8'($urandom_range(0, 255));
			default: return TERM_RESET;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin
		int start_cnt;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		queued = 0;
		hold_req = 1'b0;
		term_chr = TERM_RESET;
		wk = K_NONE;
		close_word();
		line_fields = BLOCK_CLEAR;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// Reconfigure only with the parser idle; phase 0 runs at the reset value.
			if (ph != 0) begin
				drain();
				write_term(phase_term(ph));
			end
			tx_idle = TX_IDLE_MASK[ph];
			rx_idle = RX_IDLE_MASK[ph];
			if (ph == 0) begin
				// Empty line, then the largest four-digit values, a short G word cut by a space,
				// and an L word whose four characters 0, W, minus and 9 give repeat count nine.
				queue_char(term_chr);
				queue_text("N9999G7 F9999L0W-9999999");
				queue_char(term_chr);
				hold_req = 1'b1;
			end
			start_cnt = queued;
			while (queued - start_cnt < PHASE_ITEMS)
				queue_line();
		end
		drain();

		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
